>>> hw/rtl/shab_pkg.sv
`timescale 1ns / 1ps
// shab_pkg: shared types, round constants and sigma functions for the SHA-256 hasher.
// No dependencies.
package shab_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [0:7] work_t;
    typedef word_t [0:15] sched_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_OFFSET = 6'd63;
    localparam logic [6:0] LAST_ROUND_CNT = 7'd64;
    localparam logic [6:0] MEM_ROUND_CNT = 7'd16;
    localparam logic [2:0] LAST_INDEX = 3'd7;

    localparam work_t INIT_H = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t [0:63] ROUND_K = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t bsig0(input word_t x);
        return ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
    endfunction

    function automatic word_t bsig1(input word_t x);
        return ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
    endfunction

    function automatic word_t ssig0(input word_t x);
        return ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        return ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
    endfunction

endpackage

>>> hw/rtl/shab_round.sv
`timescale 1ns / 1ps
// shab_round: one SHA-256 compression round plus message schedule expansion.
// Depends on shab_pkg.
module shab_round
(
    input  shab_pkg::work_t  v,
    input  shab_pkg::sched_t win,
    input  shab_pkg::word_t  w_mem,
    input  logic             use_mem,
    input  shab_pkg::word_t  k,
    output shab_pkg::work_t  v_out,
    output shab_pkg::word_t  w_out
);
    import shab_pkg::*;

    word_t w_sched;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    always_comb
    begin
        w_sched = win[0] + ssig0(win[1]) + win[9] + ssig1(win[14]);
        w_out   = use_mem ? w_mem : w_sched;
        ch      = (v[4] & v[5]) ^ (~v[4] & v[6]);
        maj     = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1      = v[7] + bsig1(v[4]) + ch + k + w_out;
        t2      = bsig0(v[0]) + maj;
        v_out   = '{t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
    end

endmodule

>>> hw/rtl/sha256_byte_stream_hasher_unit.sv
`timescale 1ns / 1ps
// sha256_byte_stream_hasher_unit: SHA-256 over a byte stream, top level.
// Depends on shab_pkg and shab_round.
//
// Bytes enter one per cycle while in_stall is low, into a 16 x 32-bit block memory. When a
// block fills, in_stall rises while it is compressed: 64 rounds of one round per cycle on a
// single round unit, fed by a registered memory read, followed by the chaining add. On the
// last byte the unit writes the padding and length bytes into the memory one per cycle
// while no block is being compressed (up to 64, or up to 72 when the length spills into a
// second block), compresses one or two blocks, then presents the eight digest words as
// eight output transactions, word 0 first. No input is taken until the last digest word is
// taken, after which the next message starts from the initial hash values.
module sha256_byte_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import shab_pkg::*;

    state_t       state_reg, state_next;
    state_t       ret_reg, ret_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  len_reg, len_next;
    logic         mark_reg, mark_next;
    logic         lenph_reg, lenph_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [2:0]   idx_reg, idx_next;
    work_t        h_reg, h_next;
    work_t        v_reg, v_next;
    sched_t       win_reg, win_next;
    word_t        rd_reg;

    logic [3:0][7:0] buf_mem [0:15];

    logic         accept;
    logic         wr_en;
    logic [7:0]   wr_byte;
    logic [7:0]   pad_byte;
    logic [63:0]  len_bits;
    logic         full;
    logic [5:0]   rnd;
    work_t        v_round;
    word_t        w_new;

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == LAST_INDEX);

    assign len_bits = {len_reg, 3'b000};
    assign rnd      = cnt_reg[5:0] - 6'd1;

    always_comb
    begin
        pad_byte = 8'h00;
        if (mark_reg)
            pad_byte = PAD_MARK;
        else if (lenph_reg || fill_reg == LEN_OFFSET)
            pad_byte = 8'(len_bits >> {~fill_reg[2:0], 3'b000});
    end

    assign wr_en   = accept || (state_reg == S_PAD);
    assign wr_byte = (state_reg == S_PAD) ? pad_byte : data_byte;
    assign full    = wr_en && (fill_reg == LAST_OFFSET);

    shab_round u_round
    (
        .v       (v_reg),
        .win     (win_reg),
        .w_mem   (rd_reg),
        .use_mem (cnt_reg <= MEM_ROUND_CNT),
        .k       (ROUND_K[rnd]),
        .v_out   (v_round),
        .w_out   (w_new)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[fill_reg[5:2]][~fill_reg[1:0]] <= wr_byte;
        rd_reg <= buf_mem[cnt_reg[3:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        mark_next  = mark_reg;
        lenph_next = lenph_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        win_next   = win_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fill_reg + 6'd1;
                    len_next  = len_reg + 61'd1;
                    if (last_byte)
                    begin
                        mark_next  = 1'b1;
                        state_next = S_PAD;
                    end
                    if (full)
                    begin
                        state_next = S_COMP;
                        if (last_byte)
                            ret_next = S_PAD;
                        else
                            ret_next = S_IDLE;
                        cnt_next   = '0;
                        v_next     = h_reg;
                    end
                end
            end
            S_PAD:
            begin
                fill_next = fill_reg + 6'd1;
                if (mark_reg)
                    mark_next = 1'b0;
                else if (fill_reg == LEN_OFFSET)
                    lenph_next = 1'b1;
                if (full)
                begin
                    state_next = S_COMP;
                    if (lenph_reg)
                        ret_next = S_OUT;
                    else
                        ret_next = S_PAD;
                    cnt_next   = '0;
                    v_next     = h_reg;
                end
            end
            S_COMP:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != '0)
                begin
                    v_next = v_round;
                    for (int i = 0; i < 15; i++)
                        win_next[i] = win_reg[i + 1];
                    win_next[15] = w_new;
                end
                if (cnt_reg == LAST_ROUND_CNT)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    h_next[i] = h_reg[i] + v_reg[i];
                state_next = ret_reg;
                if (ret_reg == S_OUT)
                begin
                    idx_next   = '0;
                    lenph_next = 1'b0;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == LAST_INDEX)
                    begin
                        h_next     = INIT_H;
                        fill_next  = '0;
                        len_next   = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            mark_reg  <= 1'b0;
            lenph_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            h_reg     <= INIT_H;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            mark_reg  <= mark_next;
            lenph_reg <= lenph_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        win_reg <= win_next;
    end

endmodule
